FILE: design/bptc_pkg.sv
package bptc_pkg;

  // Number of calibration registers and the APB address width that covers them.
  localparam int unsigned NumRegs  = 6;
  localparam int unsigned CfgAddrW = 5;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_PRES_SENS   = 3'd0,
    REG_PRES_OFFSET = 3'd1,
    REG_SENS_TCO    = 3'd2,
    REG_OFFSET_TCO  = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } reg_idx_e;

  // The six factory calibration words.
  typedef struct packed {
    logic [15:0] pressure_sensitivity;
    logic [15:0] pressure_offset;
    logic [15:0] sens_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] reference_temp;
    logic [15:0] temp_slope;
  } cal_t;

  // Temperature thresholds in 0.01 C for the second-order corrections.
  localparam logic signed [19:0] TempRef  = 20'sd2000;
  localparam logic signed [19:0] TempCold = -20'sd1500;

  // Output ranges.
  localparam logic signed [14:0] TempMin = -15'sd4000;
  localparam logic signed [14:0] TempMax = 15'sd8500;
  localparam logic [17:0]        PresMax = 18'h3FFFF;

endpackage

FILE: design/bptc_regs.sv
module bptc_regs
  import bptc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cal_t                cal_o
);

  cal_t     cal_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cal_o  = cal_q;

  // Register writes; indexes past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PRES_SENS:   cal_q.pressure_sensitivity <= pwdata[15:0];
        REG_PRES_OFFSET: cal_q.pressure_offset      <= pwdata[15:0];
        REG_SENS_TCO:    cal_q.sens_temp_coeff      <= pwdata[15:0];
        REG_OFFSET_TCO:  cal_q.offset_temp_coeff    <= pwdata[15:0];
        REG_REF_TEMP:    cal_q.reference_temp       <= pwdata[15:0];
        REG_TEMP_SLOPE:  cal_q.temp_slope           <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (idx)
      REG_PRES_SENS:   prdata = {16'h0000, cal_q.pressure_sensitivity};
      REG_PRES_OFFSET: prdata = {16'h0000, cal_q.pressure_offset};
      REG_SENS_TCO:    prdata = {16'h0000, cal_q.sens_temp_coeff};
      REG_OFFSET_TCO:  prdata = {16'h0000, cal_q.offset_temp_coeff};
      REG_REF_TEMP:    prdata = {16'h0000, cal_q.reference_temp};
      REG_TEMP_SLOPE:  prdata = {16'h0000, cal_q.temp_slope};
      default:         prdata = 32'h0000_0000;
    endcase
  end

endmodule

FILE: design/bptc_pipe.sv
module bptc_pipe
  import bptc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cal_t               cal_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [23:0]        raw_pressure_i,
  input  logic [23:0]        raw_temperature_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] temperature_o,
  output logic [17:0]        pressure_o,
  output logic               saturated_o
);

  localparam int unsigned NumStages = 10;

  // Stage handshake: a stage loads when it is empty or its successor moves.
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;
  logic [NumStages-1:0] vin;
  logic [NumStages-1:0] ld;

  always_comb begin
    en[NumStages-1] = ~v_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign vin        = {v_q[NumStages-2:0], in_valid_i};
  assign ld         = en & vin;
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  // Stage 0: temperature difference against the reference.
  logic signed [24:0] dt_d, dt_q;
  logic [23:0]        d1_q [6];

  assign dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cal_i.reference_temp, 8'h00});

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      dt_q    <= dt_d;
      d1_q[0] <= raw_pressure_i;
    end
  end

  // Stage 1: the four products of the temperature difference.
  logic signed [41:0] pt_d, poff_d, psens_d, pt_q, poff_q, psens_q;
  logic signed [49:0] pdd_d, pdd_q;

  always_comb begin
    pt_d    = dt_q * $signed({1'b0, cal_i.temp_slope});
    poff_d  = dt_q * $signed({1'b0, cal_i.offset_temp_coeff});
    psens_d = dt_q * $signed({1'b0, cal_i.sens_temp_coeff});
    pdd_d   = dt_q * dt_q;
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      pt_q    <= pt_d;
      poff_q  <= poff_d;
      psens_q <= psens_d;
      pdd_q   <= pdd_d;
      d1_q[1] <= d1_q[0];
    end
  end

  // Stage 2: first-order temperature, offset and sensitivity.
  logic signed [19:0] temp_d;
  logic signed [19:0] temp_q [2];
  logic signed [35:0] off_d;
  logic signed [35:0] off_q [3];
  logic signed [34:0] sens_d;
  logic signed [34:0] sens_q [3];
  logic [17:0]        t2_d;
  logic [17:0]        t2_q [2];

  always_comb begin
    temp_d = $signed({pt_q[41], pt_q[41:23]}) + TempRef;
    off_d  = $signed({poff_q[41], poff_q[41:7]})
           + $signed({4'h0, cal_i.pressure_offset, 16'h0000});
    sens_d = $signed({psens_q[41], psens_q[41:8]})
           + $signed({4'h0, cal_i.pressure_sensitivity, 15'h0000});
    t2_d   = pdd_q[48:31];
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      temp_q[0] <= temp_d;
      off_q[0]  <= off_d;
      sens_q[0] <= sens_d;
      t2_q[0]   <= t2_d;
      d1_q[2]   <= d1_q[1];
    end
  end

  // Stage 3: squared distances below the two thresholds.
  logic signed [19:0] da, db;
  logic signed [39:0] a_full, b_full;
  logic [35:0]        a_q, b_q;
  logic               lt_ref_d, lt_cold_d, lt_ref_q, lt_cold_q;

  always_comb begin
    da        = temp_q[0] - TempRef;
    db        = temp_q[0] - TempCold;
    a_full    = da * da;
    b_full    = db * db;
    lt_ref_d  = temp_q[0] < TempRef;
    lt_cold_d = temp_q[0] < TempCold;
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      a_q       <= a_full[35:0];
      b_q       <= b_full[35:0];
      lt_ref_q  <= lt_ref_d;
      lt_cold_q <= lt_cold_d;
      temp_q[1] <= temp_q[0];
      off_q[1]  <= off_q[0];
      sens_q[1] <= sens_q[0];
      t2_q[1]   <= t2_q[0];
      d1_q[3]   <= d1_q[2];
    end
  end

  // Stage 4: second-order offset and sensitivity terms, corrected temperature.
  logic [38:0]        a5, b7;
  logic [39:0]        b11;
  logic [39:0]        off2_d, sens2_d, off2_q, sens2_q;
  logic signed [20:0] tc_d;
  logic signed [20:0] tc_q [5];

  always_comb begin
    a5      = {3'b000, a_q} + {1'b0, a_q, 2'b00};
    b7      = {b_q, 3'b000} - {3'b000, b_q};
    b11     = {1'b0, b_q, 3'b000} + {3'b000, b_q, 1'b0} + {4'h0, b_q};
    off2_d  = '0;
    sens2_d = '0;
    if (lt_ref_q) begin
      off2_d  = {2'b00, a5[38:1]};
      sens2_d = {3'b000, a5[38:2]};
      if (lt_cold_q) begin
        off2_d  = off2_d + {1'b0, b7};
        sens2_d = sens2_d + {1'b0, b11[39:1]};
      end
    end
    // The squared-difference correction only applies below the reference.
    tc_d = $signed({temp_q[1][19], temp_q[1]})
         - (lt_ref_q ? $signed({3'b000, t2_q[1]}) : 21'sd0);
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      off2_q    <= off2_d;
      sens2_q   <= sens2_d;
      tc_q[0]   <= tc_d;
      off_q[2]  <= off_q[1];
      sens_q[2] <= sens_q[1];
      d1_q[4]   <= d1_q[3];
    end
  end

  // Stage 5: corrected offset and sensitivity.
  logic signed [40:0] sensc_d, sensc_q, offc_d;
  logic signed [40:0] offc_q [3];

  always_comb begin
    sensc_d = $signed({{6{sens_q[2][34]}}, sens_q[2]}) - $signed({1'b0, sens2_q});
    offc_d  = $signed({{5{off_q[2][35]}}, off_q[2]}) - $signed({1'b0, off2_q});
  end

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      sensc_q   <= sensc_d;
      offc_q[0] <= offc_d;
      tc_q[1]   <= tc_q[0];
      d1_q[5]   <= d1_q[4];
    end
  end

  // Stage 6: raw pressure times sensitivity, as two partial products.
  logic [43:0]        pplo_d, pplo_q;
  logic signed [45:0] pphi_d, pphi_q;

  always_comb begin
    pplo_d = d1_q[5] * sensc_q[19:0];
    pphi_d = $signed({1'b0, d1_q[5]}) * $signed(sensc_q[40:20]);
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      pplo_q    <= pplo_d;
      pphi_q    <= pphi_d;
      offc_q[1] <= offc_q[0];
      tc_q[2]   <= tc_q[1];
    end
  end

  // Stage 7: combine the partial products.
  logic signed [65:0] prod_d, prod_q;

  assign prod_d = $signed({pphi_q, 20'h00000}) + $signed({22'h000000, pplo_q});

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      prod_q    <= prod_d;
      offc_q[2] <= offc_q[1];
      tc_q[3]   <= tc_q[2];
    end
  end

  // Stage 8: scaled product less the corrected offset.
  logic signed [45:0] diff_d, diff_q;

  assign diff_d = $signed({prod_q[65], prod_q[65:21]})
                - $signed({{5{offc_q[2][40]}}, offc_q[2]});

  always_ff @(posedge clk_i) begin
    if (ld[8]) begin
      diff_q  <= diff_d;
      tc_q[4] <= tc_q[3];
    end
  end

  // Stage 9: final scaling and saturation into the output register.
  logic signed [30:0] pres_raw;
  logic signed [14:0] temperature_d, temperature_q;
  logic [17:0]        pressure_d, pressure_q;
  logic               sat_t, sat_p, sat_q;

  always_comb begin
    pres_raw = diff_q[45:15];
    sat_t    = 1'b1;
    sat_p    = 1'b1;
    if (tc_q[4] < TempMin) begin
      temperature_d = TempMin;
    end else if (tc_q[4] > TempMax) begin
      temperature_d = TempMax;
    end else begin
      temperature_d = tc_q[4][14:0];
      sat_t         = 1'b0;
    end
    if (pres_raw < 0) begin
      pressure_d = '0;
    end else if (pres_raw > $signed({13'h0000, PresMax})) begin
      pressure_d = PresMax;
    end else begin
      pressure_d = pres_raw[17:0];
      sat_p      = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[9]) begin
      temperature_q <= temperature_d;
      pressure_q    <= pressure_d;
      sat_q         <= sat_t | sat_p;
    end
  end

  assign out_valid_o   = v_q[NumStages-1];
  assign temperature_o = temperature_q;
  assign pressure_o    = pressure_q;
  assign saturated_o   = sat_q;

endmodule

FILE: design/baro_pressure_temp_compensation.sv
// Channel     Direction  Width  Contents
// s_axis      in         48     raw_pressure [23:0], raw_temperature [47:24]
// m_axis      out        40+1   temperature [14:0], pressure [32:15]; tuser saturated
// apb         in/out     32     six 16-bit calibration words at byte offsets 0..20
//
// A sample pair passes through a ten-stage pipeline from its request to the result
// register; one pair is accepted every cycle while results are taken.
// Each stage holds its contents while the stage after it is full and stalled, so an
// empty stage still takes new data while a result waits on m_axis.
// Reset clears the stage valid bits and the calibration words to zero.
module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Sample pair in.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,   // raw_pressure, raw_temperature
  // Result out.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,   // temperature, pressure, zero fill
  output logic                m_axis_tuser,   // saturated
  // Calibration registers.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cal_t               cal;
  logic signed [14:0] temperature;
  logic [17:0]        pressure;
  logic               saturated;

  // Calibration register file.
  bptc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal_o   (cal)
  );

  // Compensation pipeline.
  bptc_pipe u_pipe (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cal_i             (cal),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .raw_pressure_i    (s_axis_tdata[23:0]),
    .raw_temperature_i (s_axis_tdata[47:24]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .temperature_o     (temperature),
    .pressure_o        (pressure),
    .saturated_o       (saturated)
  );

  assign m_axis_tdata = {7'h00, pressure, temperature};
  assign m_axis_tuser = saturated;

  // The input side only stalls when a finished result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled result");

  // A clamped result sits on one of the range bounds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (temperature == TempMin || temperature == TempMax ||
       pressure == '0 || pressure == PresMax))
    else $error("saturation flag without a clamped value");

  // Temperature never leaves its range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (temperature >= TempMin && temperature <= TempMax))
    else $error("temperature out of range");

  // A write to the first register lands its low half-word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[CfgAddrW-1:2] == REG_PRES_SENS) |=>
      (cal.pressure_sensitivity == $past(pwdata[15:0])))
    else $error("calibration write lost");

endmodule
